// ----- sv/tblr_pkg.sv -----
`default_nettype none
package tblr_pkg;

   localparam int TOTAL_LINES    = 154;
   localparam int VISIBLE_LINES  = 144;
   localparam int TILES_PER_LINE = 20;

   localparam int VRAM_DEPTH  = 8192;
   localparam int VRAM_ADDR_W = 13;
   localparam int BYTE_W      = 8;
   localparam int LINE_W      = 8;
   localparam int COL_W       = 5;
   localparam int PIX_W       = 16;

   localparam logic [VRAM_ADDR_W-1:0] MAP_LOW_OFF       = 13'h1800;
   localparam logic [VRAM_ADDR_W-1:0] MAP_HIGH_OFF      = 13'h1C00;
   localparam logic [VRAM_ADDR_W-1:0] DATA_UNSIGNED_OFF = 13'h0000;
   localparam logic [VRAM_ADDR_W-1:0] DATA_SIGNED_OFF   = 13'h1000;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam logic [1:0] SEL_MAP = 2'd0;
   localparam logic [1:0] SEL_LO  = 2'd1;
   localparam logic [1:0] SEL_HI  = 2'd2;

   localparam logic CSR_MAP_HIGH   = 1'b0;
   localparam logic CSR_SIGNED_IDX = 1'b1;

   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic [1:0]       rd_sel;
      logic             line_adv;
      logic             lo_load;
      logic             out_load;
      logic             out_blank;
      logic             last;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] map_col;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic next_blank;
   } status_type;

   function automatic logic [PIX_W-1:0] interleave(input logic [BYTE_W-1:0] lo,
                                                   input logic [BYTE_W-1:0] hi);
      logic [PIX_W-1:0] r;
      r = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         r[2*i]   = lo[i];
         r[2*i+1] = hi[i];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- sv/tblr_ram.sv -----
`default_nettype none
module tblr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- sv/tblr_ctrl.sv -----
`default_nettype none
module tblr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_type,
   output logic                      req_tready,
   input  wire tblr_pkg::status_type status,
   output tblr_pkg::cmd_type         cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAP   = 3'd1;
   localparam logic [2:0] S_TILE  = 3'd2;
   localparam logic [2:0] S_LO    = 3'd3;
   localparam logic [2:0] S_HI    = 3'd4;
   localparam logic [2:0] S_BLANK = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [tblr_pkg::COL_W-1:0] col_ff, col_in;
   logic                       last_col;

   assign last_col = col_ff == tblr_pkg::COL_W'(tblr_pkg::TILES_PER_LINE - 1);

   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.col        = col_ff;
      cmd.map_col    = col_ff;
      cmd.last       = last_col;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_type == tblr_pkg::REQ_TICK) begin
                  cmd.line_adv = 1'b1;
                  col_in       = '0;
                  state_in     = status.next_blank ? S_BLANK : S_MAP;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         S_MAP: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tblr_pkg::SEL_MAP;
            state_in   = S_TILE;
         end
         S_TILE: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = tblr_pkg::SEL_LO;
            state_in   = S_LO;
         end
         S_LO: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = tblr_pkg::SEL_HI;
            cmd.lo_load = 1'b1;
            state_in    = S_HI;
         end
         S_HI: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (last_col) begin
                  state_in = S_IDLE;
               end else begin
                  col_in      = col_ff + 1'b1;
                  cmd.map_col = col_in;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = tblr_pkg::SEL_MAP;
                  state_in    = S_TILE;
               end
            end
         end
         S_BLANK: begin
            if (status.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_blank = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
      end
   end

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over an untaken beat");

   a_port_single_use: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("read and write on the memory port together");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < tblr_pkg::COL_W'(tblr_pkg::TILES_PER_LINE))
      else $error("tile column out of range");

   a_tick_starts_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid && req_type == tblr_pkg::REQ_TICK
       && !status.next_blank) |=> (state_ff == S_MAP && col_ff == '0))
      else $error("visible tick did not start a fetch");

   a_blank_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLANK && status.out_free) |=> state_ff == S_IDLE)
      else $error("blank line did not finish");

endmodule
`default_nettype wire

// ----- sv/tblr_datapath.sv -----
`default_nettype none
module tblr_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [tblr_pkg::VRAM_ADDR_W-1:0]     vram_addr,
   input  wire logic [tblr_pkg::BYTE_W-1:0]          vram_data,
   input  wire logic                                 csr_we,
   input  wire logic                                 csr_index,
   input  wire logic                                 csr_wdata,
   input  wire tblr_pkg::cmd_type                    cmd,
   output tblr_pkg::status_type                      status,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [tblr_pkg::LINE_W-1:0]               line_number,
   output logic [tblr_pkg::COL_W-1:0]                tile_column,
   output logic [tblr_pkg::PIX_W-1:0]                pixel_colours,
   output logic                                      in_vblank,
   output logic                                      last_of_line
);

   logic                               map_high_ff;
   logic                               signed_idx_ff;
   logic [tblr_pkg::LINE_W-1:0]        line_ff, line_next;
   logic [tblr_pkg::VRAM_ADDR_W-1:0]   addr_ff;
   logic [tblr_pkg::BYTE_W-1:0]        lo_ff;
   logic [tblr_pkg::BYTE_W-1:0]        rd_data;
   logic [tblr_pkg::VRAM_ADDR_W-1:0]   ram_addr, map_addr, tile_addr, tile_base, map_base;
   logic                               out_valid_ff;
   logic [tblr_pkg::LINE_W-1:0]        out_line_ff;
   logic [tblr_pkg::COL_W-1:0]         out_col_ff;
   logic [tblr_pkg::PIX_W-1:0]         out_pix_ff;
   logic                               out_blank_ff;
   logic                               out_last_ff;

   assign line_next = (line_ff == tblr_pkg::LINE_W'(tblr_pkg::TOTAL_LINES - 1)) ? '0
                                                                               : line_ff + 1'b1;
   assign status.next_blank = line_next >= tblr_pkg::LINE_W'(tblr_pkg::VISIBLE_LINES);
   assign status.out_free   = !out_valid_ff || rsp_tready;

   assign map_base = map_high_ff ? tblr_pkg::MAP_HIGH_OFF : tblr_pkg::MAP_LOW_OFF;
   assign map_addr = map_base
                   + tblr_pkg::VRAM_ADDR_W'({line_ff[tblr_pkg::LINE_W-1:3], 5'b0})
                   + tblr_pkg::VRAM_ADDR_W'(cmd.map_col);

   assign tile_base = signed_idx_ff
      ? tblr_pkg::VRAM_ADDR_W'({rd_data[7], rd_data, 4'b0}) + tblr_pkg::DATA_SIGNED_OFF
      : tblr_pkg::VRAM_ADDR_W'({1'b0, rd_data, 4'b0}) + tblr_pkg::DATA_UNSIGNED_OFF;
   assign tile_addr = tile_base + tblr_pkg::VRAM_ADDR_W'({line_ff[2:0], 1'b0});

   always_comb begin
      case (cmd.rd_sel)
         tblr_pkg::SEL_MAP: ram_addr = map_addr;
         tblr_pkg::SEL_LO:  ram_addr = tile_addr;
         tblr_pkg::SEL_HI:  ram_addr = addr_ff + 1'b1;
         default:           ram_addr = map_addr;
      endcase
      if (cmd.wr_en) begin
         ram_addr = vram_addr;
      end
   end

   tblr_ram #(
      .WIDTH (tblr_pkg::BYTE_W),
      .DEPTH (tblr_pkg::VRAM_DEPTH)
   ) u_vram (
      .clock (clock),
      .en    (cmd.wr_en | cmd.rd_en),
      .we    (cmd.wr_en),
      .addr  (ram_addr),
      .wdata (vram_data),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_high_ff   <= 1'b0;
         signed_idx_ff <= 1'b0;
         line_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tblr_pkg::CSR_MAP_HIGH:   map_high_ff   <= csr_wdata;
               tblr_pkg::CSR_SIGNED_IDX: signed_idx_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.line_adv) begin
            line_ff <= line_next;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en && cmd.rd_sel == tblr_pkg::SEL_LO) begin
         addr_ff <= tile_addr;
      end
      if (cmd.lo_load) begin
         lo_ff <= rd_data;
      end
      if (cmd.out_load) begin
         out_line_ff  <= line_ff;
         out_col_ff   <= cmd.out_blank ? '0 : cmd.col;
         out_pix_ff   <= cmd.out_blank ? '0 : tblr_pkg::interleave(lo_ff, rd_data);
         out_blank_ff <= cmd.out_blank;
         out_last_ff  <= cmd.out_blank | cmd.last;
      end
   end

   assign rsp_tvalid    = out_valid_ff;
   assign line_number   = out_line_ff;
   assign tile_column   = out_col_ff;
   assign pixel_colours = out_pix_ff;
   assign in_vblank     = out_blank_ff;
   assign last_of_line  = out_last_ff;

endmodule
`default_nettype wire

// ----- sv/tile_background_line_renderer_unit.sv -----
// Background scanline renderer for 2-bit-per-pixel tiles.
// req channel: tuser = 0 writes vram_data into video memory at vram_addr,
// tuser = 1 is a line tick. Writes give no beat.
// A tick advances the line counter (wraps after line 153). A line in
// vertical blank gives one beat with in_vblank and tlast set. A visible
// line gives 20 beats, one per tile column, tlast on the last; each
// column reads the map byte, then the low and high tile bytes, through
// the single-port video memory. req_tready is high only while no tick is
// in progress.
// rsp beats sit in an output register; while the receiver holds tready low
// the fetch stalls on the pending column and resumes once the beat is taken.
// Reset clears the line counter and both control registers; video memory
// content is undefined until written. csr writes take effect at once and
// are meant for idle periods.
`default_nettype none
module tile_background_line_renderer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // vram_addr[12:0], vram_data[20:13], zero pad
   input  wire logic        req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // line_number[7:0], tile_column[12:8], pixel_colours[28:13]
   output logic             rsp_tuser,  // in_vblank
   output logic             rsp_tlast,  // last_of_line
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata
);

   tblr_pkg::cmd_type              cmd;
   tblr_pkg::status_type           status;
   logic [tblr_pkg::LINE_W-1:0]    line_number;
   logic [tblr_pkg::COL_W-1:0]     tile_column;
   logic [tblr_pkg::PIX_W-1:0]     pixel_colours;

   tblr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tblr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .vram_addr     (req_tdata[12:0]),
      .vram_data     (req_tdata[20:13]),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .line_number   (line_number),
      .tile_column   (tile_column),
      .pixel_colours (pixel_colours),
      .in_vblank     (rsp_tuser),
      .last_of_line  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, pixel_colours, tile_column, line_number};

endmodule
`default_nettype wire
